// ===== src/b64le_pkg.sv =====
// Package for the Base64 line encoder: shared constants, the job record that
// travels from the front end to the back end, and the digit alphabet function.
// Depends on nothing.
package b64le_pkg;

  localparam int unsigned ByteW      = 8;
  localparam int unsigned MaxChars   = 6;
  localparam int unsigned CountW     = 3;
  localparam int unsigned QueueDepth = 4;

  localparam logic [ByteW-1:0] ResetChunkBytes = 8'd54;
  localparam logic [ByteW-1:0] PadChar         = 8'h3D;
  localparam logic [ByteW-1:0] CrChar          = 8'h0D;
  localparam logic [ByteW-1:0] LfChar          = 8'h0A;

  // Codes for the number of leftover bits held between bytes.
  localparam logic [2:0] LeftNone = 3'd0;
  localparam logic [2:0] LeftTwo  = 3'd2;
  localparam logic [2:0] LeftFour = 3'd4;

  // All characters that one input byte causes, in emission order.
  typedef struct packed {
    logic [MaxChars-1:0][ByteW-1:0] chars;
    logic [CountW-1:0]              count;
  } job_t;

  // Maps a 6-bit value onto the standard Base64 alphabet.
  function automatic logic [ByteW-1:0] b64_char(input logic [5:0] v);
    logic [ByteW-1:0] c;
    if (v < 6'd26) begin
      c = 8'h41 + {2'b00, v};
    end else if (v < 6'd52) begin
      c = 8'h61 + {2'b00, v} - 8'd26;
    end else if (v < 6'd62) begin
      c = 8'h30 + {2'b00, v} - 8'd52;
    end else if (v == 6'd62) begin
      c = 8'h2B;
    end else begin
      c = 8'h2F;
    end
    return c;
  endfunction

endpackage

// ===== src/base64_line_encoder.sv =====
// Top level of the Base64 line encoder. Instantiates the front end, the job
// queue and the back end. Depends on b64le_pkg and the three b64le modules.

// The encoder takes a stream of bytes and emits Base64 text, one line per
// chunk of cfg bytes (54 after reset, 0 meaning 256), each line closed with
// '=' padding as needed and CR LF; a byte with in_final_byte set ends the
// current line early. Every byte yields one to six characters, and the last
// character of each byte carries out_run_end. The front end takes one byte per
// cycle whenever the job queue has room, so the input never waits on the
// output directly. The back end sends exactly one character per cycle while
// it holds a job and out_ready is high, so the sustained rate is set by the
// output. An accepted byte passes through the queue memory and then the back
// end's job register before its first character is offered. The chunk size
// may only be rewritten while the encoder is idle, and a new size takes
// effect on the next byte.
module base64_line_encoder #(
  parameter int unsigned QUEUE_DEPTH = b64le_pkg::QueueDepth
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_final_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_run_end
);

  // Jobs travel from the front end through the queue to the back end.
  b64le_pkg::job_t push_data, pop_data;
  logic            push_valid, push_ready;
  logic            pop_valid, pop_ready;

  // The front end owns the chunk size register and all encoding state.
  b64le_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_final_byte (in_final_byte),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_data     (push_data)
  );

  // The queue lets the input keep flowing while a long line end drains.
  b64le_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // The back end holds the current job in registers and drives the output.
  b64le_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_data    (pop_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_char    (out_char),
    .out_run_end (out_run_end)
  );

endmodule

// ===== src/b64le_front.sv =====
// Front end of the Base64 line encoder: accepts bytes, tracks the bit and
// chunk state, and turns each byte into a job of up to six characters.
// Depends on b64le_pkg.
module b64le_front (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_wr_en,
  input  logic [7:0]                 cfg_wr_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_data_byte,
  input  logic                       in_final_byte,
  output logic                       push_valid,
  input  logic                       push_ready,
  output b64le_pkg::job_t            push_data
);

  logic [7:0] chunk_bytes_r;
  logic [3:0] left_bits_r, left_bits_nxt;
  logic [2:0] left_cnt_r, left_cnt_nxt;
  logic [7:0] chunk_pos_r, chunk_pos_nxt;
  logic [1:0] digits_r, digits_nxt;

  logic [8:0] next_pos;
  logic [8:0] limit;
  logic       chunk_end;
  logic [5:0] v0, v1;
  logic [1:0] nd;
  logic [3:0] lb_n;
  logic [2:0] lc_n;
  logic [1:0] dig_sum;
  logic [1:0] pads;
  logic [2:0] pad_end;
  logic       accept;

  assign in_ready   = push_ready;
  assign push_valid = in_valid;
  assign accept     = in_valid && push_ready;

  assign next_pos  = {1'b0, chunk_pos_r} + 9'd1;
  assign limit     = (chunk_bytes_r == 8'd0) ? 9'd256 : {1'b0, chunk_bytes_r};
  assign chunk_end = in_final_byte || (next_pos >= limit);

  always_comb begin
    v1   = 6'd0;
    nd   = 2'd1;
    unique case (left_cnt_r)
      b64le_pkg::LeftTwo: begin
        v0   = {left_bits_r[1:0], in_data_byte[7:4]};
        lb_n = in_data_byte[3:0];
        lc_n = b64le_pkg::LeftFour;
      end
      b64le_pkg::LeftFour: begin
        v0   = {left_bits_r, in_data_byte[7:6]};
        v1   = in_data_byte[5:0];
        nd   = 2'd2;
        lb_n = 4'd0;
        lc_n = b64le_pkg::LeftNone;
      end
      default: begin
        v0   = in_data_byte[7:2];
        lb_n = {2'b00, in_data_byte[1:0]};
        lc_n = b64le_pkg::LeftTwo;
      end
    endcase

    // Closing a chunk flushes the leftover bits as one zero-filled digit.
    if (chunk_end && lc_n == b64le_pkg::LeftTwo) begin
      v1 = {lb_n[1:0], 4'b0000};
      nd = 2'd2;
    end else if (chunk_end && lc_n == b64le_pkg::LeftFour) begin
      v1 = {lb_n, 2'b00};
      nd = 2'd2;
    end

    dig_sum = digits_r + nd;
    pads    = chunk_end ? (2'd0 - dig_sum) : 2'd0;
    pad_end = {1'b0, nd} + {1'b0, pads};

    push_data.count = chunk_end ? (pad_end + 3'd2) : {1'b0, nd};
    for (int i = 0; i < b64le_pkg::MaxChars; i++) begin
      if (3'(i) == 3'd0) begin
        push_data.chars[i] = b64le_pkg::b64_char(v0);
      end else if (3'(i) < {1'b0, nd}) begin
        push_data.chars[i] = b64le_pkg::b64_char(v1);
      end else if (3'(i) < pad_end) begin
        push_data.chars[i] = b64le_pkg::PadChar;
      end else if (3'(i) == pad_end) begin
        push_data.chars[i] = b64le_pkg::CrChar;
      end else begin
        push_data.chars[i] = b64le_pkg::LfChar;
      end
    end

    if (chunk_end) begin
      left_bits_nxt = 4'd0;
      left_cnt_nxt  = b64le_pkg::LeftNone;
      chunk_pos_nxt = 8'd0;
      digits_nxt    = 2'd0;
    end else begin
      left_bits_nxt = lb_n;
      left_cnt_nxt  = lc_n;
      chunk_pos_nxt = next_pos[7:0];
      digits_nxt    = dig_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_bytes_r <= b64le_pkg::ResetChunkBytes;
      left_bits_r   <= 4'd0;
      left_cnt_r    <= b64le_pkg::LeftNone;
      chunk_pos_r   <= 8'd0;
      digits_r      <= 2'd0;
    end else begin
      if (cfg_wr_en) begin
        chunk_bytes_r <= cfg_wr_data;
      end
      if (accept) begin
        left_bits_r <= left_bits_nxt;
        left_cnt_r  <= left_cnt_nxt;
        chunk_pos_r <= chunk_pos_nxt;
        digits_r    <= digits_nxt;
      end
    end
  end

endmodule

// ===== src/b64le_queue.sv =====
// Job queue between the front and back ends of the Base64 line encoder.
// A small circular buffer of job records. Depends on b64le_pkg.
module b64le_queue #(
  parameter int unsigned DEPTH = b64le_pkg::QueueDepth
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  b64le_pkg::job_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output b64le_pkg::job_t pop_data
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(DEPTH - 1);
  localparam logic [CntW-1:0] Full    = CntW'(DEPTH);

  b64le_pkg::job_t mem [DEPTH];

  logic [PtrW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CntW-1:0] fill_r;
  logic            do_push, do_pop;

  assign push_ready = (fill_r != Full);
  assign pop_valid  = (fill_r != '0);
  assign pop_data   = mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LastPtr) ? '0 : wr_ptr_r + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LastPtr) ? '0 : rd_ptr_r + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        fill_r <= fill_r + CntW'(1);
      end else if (do_pop && !do_push) begin
        fill_r <= fill_r - CntW'(1);
      end
    end
  end

endmodule

// ===== src/b64le_back.sv =====
// Back end of the Base64 line encoder: holds one job and sends its
// characters one per transaction, marking the last. Depends on b64le_pkg.
module b64le_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            pop_valid,
  output logic            pop_ready,
  input  b64le_pkg::job_t pop_data,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_char,
  output logic            out_run_end
);

  b64le_pkg::job_t job_r;
  logic [2:0]      idx_r;
  logic            busy_r;
  logic            last;

  assign last        = (idx_r == job_r.count - 3'd1);
  assign out_valid   = busy_r;
  assign out_char    = job_r.chars[idx_r];
  assign out_run_end = last;
  assign pop_ready   = !busy_r || (out_ready && last);

  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      job_r <= pop_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= 3'd0;
    end else if (pop_valid && pop_ready) begin
      busy_r <= 1'b1;
      idx_r  <= 3'd0;
    end else if (busy_r && out_ready) begin
      if (last) begin
        busy_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 3'd1;
      end
    end
  end

endmodule

// ===== src/b64le_checker.sv =====
// Port-level checks for the Base64 line encoder, bound to the top level.
// Depends on b64le_pkg and base64_line_encoder.
module b64le_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_char,
  input logic       out_run_end
);

  // A stalled output transaction holds its character and marker.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_run_end))
    else $error("output changed while stalled");

  // A CR sent is always followed at once by its LF from the same job.
  a_cr_lf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_char == b64le_pkg::CrChar
    |=> out_valid && out_char == b64le_pkg::LfChar)
    else $error("CR not followed by LF");

  // The LF that closes a line is always the last character of its byte.
  a_lf_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_char == b64le_pkg::LfChar |-> out_run_end)
    else $error("LF without run end");

  // Nothing is offered in the first cycle after reset.
  a_reset_idle: assert property (@(posedge clk)
    rst_n && $past(!rst_n) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

bind base64_line_encoder b64le_checker u_b64le_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_char    (out_char),
  .out_run_end (out_run_end)
);
